FILE: design/cpose_pkg.sv
// shared types, constants and arctangent table for the camera pose block
package cpose_pkg;

    // cordic configuration
    localparam int CORDIC_STAGES = 14;
    localparam int ATAN_COUNT    = 20;
    localparam int CORDIC_ITERS  = (CORDIC_STAGES < ATAN_COUNT) ? CORDIC_STAGES : ATAN_COUNT;

    // datapath widths
    localparam int ZW = 34;   // angle accumulator, q.30
    localparam int XW = 33;   // cordic x and y, q.30 with headroom
    localparam int SW = 32;   // sine and cosine after the cordic
    localparam int PW = 64;   // product of two sines or cosines, q.60

    // q.30 angle constants
    localparam logic signed [ZW-1:0] Q30_PI       = 34'sd3373259426;
    localparam logic signed [ZW-1:0] Q30_HALF_PI  = 34'sd1686629713;
    localparam logic signed [XW-1:0] Q30_INV_GAIN = 33'sd652032874;

    // atan(2^-i) in q.30
    localparam logic signed [ZW-1:0] ATAN_Q30 [ATAN_COUNT] = '{
        34'sd843314857, 34'sd497837830, 34'sd263043837, 34'sd133525159,
        34'sd67021688,  34'sd33543515,  34'sd16775851,  34'sd8388437,
        34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
        34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
        34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048
    };

    // q1.14 limits and position limits
    localparam logic signed [15:0] Q14_ONE  = 16'sd16384;
    localparam logic signed [31:0] POS_MIN  = 32'sh8000_0000;
    localparam logic signed [31:0] POS_MAX  = 32'sh7fff_ffff;

    // pose row codes
    localparam logic [1:0] ROW_TOP = 2'd0;
    localparam logic [1:0] ROW_MID = 2'd1;
    localparam logic [1:0] ROW_BOT = 2'd2;

    // one input transfer
    typedef struct packed {
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
        logic signed [31:0] pos_forward;
        logic signed [31:0] pos_right;
        logic signed [31:0] pos_up;
        logic        [31:0] view_angle;
    } angle_t;

    // one result transfer
    typedef struct packed {
        logic        [1:0]  row_index;
        logic signed [15:0] entry_a;
        logic signed [15:0] entry_b;
        logic signed [15:0] entry_c;
        logic signed [31:0] shift_part;
        logic        [31:0] view_out;
        logic               last_row;
    } row_t;

    // position and view words riding along the pipeline
    typedef struct packed {
        logic signed [31:0] pos_forward;
        logic signed [31:0] pos_right;
        logic signed [31:0] pos_up;
        logic        [31:0] view_angle;
    } carry_t;

endpackage

FILE: design/camera_pose_from_pitch_yaw.sv
// camera pose from pitch and yaw: cordic pipeline and row serializer
//
// Input channel angle_*: one transfer carries pitch and yaw (q3.13 radians),
// a q16.16 position and a field-of-view word. Output channel row_*: each
// input produces three transfers, rows 0, 1 and 2 of a 3x4 camera-to-world
// pose, the last one marked by last_row. Rotation entries are q1.14.
// The first row appears once the input has passed the cordic stages, the
// sign fix, multiply and rounding stages and the row buffer; rows 1 and 2
// follow while row_stall is low. Throughput is set by the single output
// channel that sends three rows per pose; the pipeline itself takes an
// item every cycle while angle_stall is low. Pitch and yaw run through two
// cordic lanes side by side, one iteration per stage, then a sign fix
// stage, a multiply stage and a rounding stage feed a row buffer.
// Reset clears all valid bits and the row counter, not the data registers.
// When the receiver stalls, the row buffer holds its current row, the
// pipeline freezes once its last stage is full and angle_stall rises;
// nothing is dropped or repeated.
module camera_pose_from_pitch_yaw (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               angle_valid,
    output logic               angle_stall,
    input  cpose_pkg::angle_t  angle_data,
    output logic               row_valid,
    input  logic               row_stall,
    output cpose_pkg::row_t    row_data
);

    localparam int ITERS = cpose_pkg::CORDIC_ITERS;
    localparam int NSTG  = ITERS + 4;
    localparam int ST_M  = ITERS + 2;
    localparam int ST_R  = ITERS + 3;
    localparam int ZW    = cpose_pkg::ZW;
    localparam int XW    = cpose_pkg::XW;
    localparam int SW    = cpose_pkg::SW;
    localparam int PW    = cpose_pkg::PW;
    localparam int LP    = 0;   // pitch lane
    localparam int LY    = 1;   // yaw lane

    // round q.30 to q1.14 with saturation
    function automatic logic signed [15:0] rnd30(input logic signed [XW-1:0] v);
        logic signed [XW:0]    t;
        logic signed [XW-16:0] r;
        t = {v[XW-1], v} + (XW+1)'(33'sd32768);
        r = t[XW:16];
        if (r > (XW-15)'(cpose_pkg::Q14_ONE))
            return cpose_pkg::Q14_ONE;
        else if (r < -(XW-15)'(cpose_pkg::Q14_ONE))
            return -cpose_pkg::Q14_ONE;
        else
            return r[15:0];
    endfunction

    // round q.60 to q1.14 with saturation
    function automatic logic signed [15:0] rnd60(input logic signed [PW:0] v);
        logic signed [PW+1:0]  t;
        logic signed [PW-45:0] r;
        t = {v[PW], v} + ((PW+2)'(1) << 45);
        r = t[PW+1:46];
        if (r > (PW-44)'(cpose_pkg::Q14_ONE))
            return cpose_pkg::Q14_ONE;
        else if (r < -(PW-44)'(cpose_pkg::Q14_ONE))
            return -cpose_pkg::Q14_ONE;
        else
            return r[15:0];
    endfunction

    // pipeline control
    logic [NSTG-1:0]   vld_reg;
    cpose_pkg::carry_t carry_reg [NSTG];
    logic              advance;
    logic              buf_free;
    logic              load;

    // cordic lanes
    logic signed [ZW-1:0] z_reg  [ITERS+1][2];
    logic signed [ZW-1:0] z_next [ITERS+1][2];
    logic signed [XW-1:0] cx_reg  [ITERS+1][2];
    logic signed [XW-1:0] cx_next [ITERS+1][2];
    logic signed [XW-1:0] cy_reg  [ITERS+1][2];
    logic signed [XW-1:0] cy_next [ITERS+1][2];
    logic                 flip_reg  [ITERS+1][2];
    logic                 flip_next [ITERS+1][2];
    logic signed [ZW-1:0] z_wide [2];
    logic signed [XW-1:0] dx [ITERS][2];
    logic signed [XW-1:0] dy [ITERS][2];

    // sign fix, multiply and rounding stages
    logic signed [SW-1:0] sin_reg [2];
    logic signed [SW-1:0] cos_reg [2];
    logic signed [SW-1:0] sin_m_reg [2];
    logic signed [SW-1:0] cos_m_reg [2];
    logic signed [PW-1:0] sysp_reg, sycp_reg, cysp_reg, cycp_reg;
    logic signed [15:0]   ent_reg [9];
    logic signed [15:0]   ent_next [9];
    logic signed [31:0]   trans_reg [3];
    logic signed [31:0]   neg_up;

    // row buffer
    logic signed [15:0] ent_buf_reg [9];
    logic signed [31:0] trans_buf_reg [3];
    logic        [31:0] view_buf_reg;
    logic        [1:0]  row_reg;
    logic               bvld_reg;

    // handshake: the whole pipeline moves when its tail can empty
    assign buf_free    = !bvld_reg || (!row_stall && row_reg == cpose_pkg::ROW_BOT);
    assign load        = vld_reg[ST_R] && buf_free;
    assign advance     = !vld_reg[ST_R] || buf_free;
    assign angle_stall = !advance;

    // angle widening and fold into [-pi/2, pi/2], then one cordic rotation per stage
    always_comb
    begin
        z_wide[LP] = {angle_data.pitch_angle[15], angle_data.pitch_angle, 17'b0};
        z_wide[LY] = {angle_data.yaw_angle[15], angle_data.yaw_angle, 17'b0};
        for (int l = 0; l < 2; l++)
        begin
            cx_next[0][l] = cpose_pkg::Q30_INV_GAIN;
            cy_next[0][l] = '0;
            if (z_wide[l] > cpose_pkg::Q30_HALF_PI)
            begin
                z_next[0][l]    = z_wide[l] - cpose_pkg::Q30_PI;
                flip_next[0][l] = 1'b1;
            end
            else if (z_wide[l] < -cpose_pkg::Q30_HALF_PI)
            begin
                z_next[0][l]    = z_wide[l] + cpose_pkg::Q30_PI;
                flip_next[0][l] = 1'b1;
            end
            else
            begin
                z_next[0][l]    = z_wide[l];
                flip_next[0][l] = 1'b0;
            end
        end
        // one cordic rotation per stage
        for (int s = 0; s < ITERS; s++)
        begin
            for (int l = 0; l < 2; l++)
            begin
                dx[s][l] = cy_reg[s][l] >>> s;
                dy[s][l] = cx_reg[s][l] >>> s;
                flip_next[s+1][l] = flip_reg[s][l];
                if (!z_reg[s][l][ZW-1])
                begin
                    cx_next[s+1][l] = cx_reg[s][l] - dx[s][l];
                    cy_next[s+1][l] = cy_reg[s][l] + dy[s][l];
                    z_next[s+1][l]  = z_reg[s][l] - cpose_pkg::ATAN_Q30[s];
                end
                else
                begin
                    cx_next[s+1][l] = cx_reg[s][l] + dx[s][l];
                    cy_next[s+1][l] = cy_reg[s][l] - dy[s][l];
                    z_next[s+1][l]  = z_reg[s][l] + cpose_pkg::ATAN_Q30[s];
                end
            end
        end
    end

    // rotation entries and negated up position
    always_comb
    begin
        ent_next[0] = rnd30({cos_m_reg[LY][SW-1], cos_m_reg[LY]});
        ent_next[1] = rnd60({sysp_reg[PW-1], sysp_reg});
        ent_next[2] = rnd60({sycp_reg[PW-1], sycp_reg});
        ent_next[3] = '0;
        ent_next[4] = rnd30(-{cos_m_reg[LP][SW-1], cos_m_reg[LP]});
        ent_next[5] = rnd30({sin_m_reg[LP][SW-1], sin_m_reg[LP]});
        ent_next[6] = rnd30({sin_m_reg[LY][SW-1], sin_m_reg[LY]});
        ent_next[7] = rnd60(-{cysp_reg[PW-1], cysp_reg});
        ent_next[8] = rnd60(-{cycp_reg[PW-1], cycp_reg});
        if (carry_reg[ST_M].pos_up == cpose_pkg::POS_MIN)
            neg_up = cpose_pkg::POS_MAX;
        else
            neg_up = -carry_reg[ST_M].pos_up;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (advance)
            vld_reg <= {vld_reg[NSTG-2:0], angle_valid};
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            carry_reg[0] <= {angle_data.pos_forward, angle_data.pos_right,
                             angle_data.pos_up, angle_data.view_angle};
            for (int s = 1; s < NSTG; s++)
                carry_reg[s] <= carry_reg[s-1];
            for (int s = 0; s <= ITERS; s++)
            begin
                for (int l = 0; l < 2; l++)
                begin
                    z_reg[s][l]    <= z_next[s][l];
                    cx_reg[s][l]   <= cx_next[s][l];
                    cy_reg[s][l]   <= cy_next[s][l];
                    flip_reg[s][l] <= flip_next[s][l];
                end
            end
            // sign fix after the fold
            for (int l = 0; l < 2; l++)
            begin
                if (flip_reg[ITERS][l])
                begin
                    sin_reg[l] <= SW'(-cy_reg[ITERS][l]);
                    cos_reg[l] <= SW'(-cx_reg[ITERS][l]);
                end
                else
                begin
                    sin_reg[l] <= SW'(cy_reg[ITERS][l]);
                    cos_reg[l] <= SW'(cx_reg[ITERS][l]);
                end
                sin_m_reg[l] <= sin_reg[l];
                cos_m_reg[l] <= cos_reg[l];
            end
            // products of yaw and pitch terms
            sysp_reg <= sin_reg[LY] * sin_reg[LP];
            sycp_reg <= sin_reg[LY] * cos_reg[LP];
            cysp_reg <= cos_reg[LY] * sin_reg[LP];
            cycp_reg <= cos_reg[LY] * cos_reg[LP];
            // rounding stage
            for (int k = 0; k < 9; k++)
                ent_reg[k] <= ent_next[k];
            trans_reg[0] <= carry_reg[ST_M].pos_forward;
            trans_reg[1] <= neg_up;
            trans_reg[2] <= carry_reg[ST_M].pos_right;
        end
    end

    // row buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bvld_reg <= 1'b0;
            row_reg  <= cpose_pkg::ROW_TOP;
        end
        else if (load)
        begin
            bvld_reg <= 1'b1;
            row_reg  <= cpose_pkg::ROW_TOP;
        end
        else if (bvld_reg && !row_stall)
        begin
            if (row_reg == cpose_pkg::ROW_BOT)
                bvld_reg <= 1'b0;
            else
                row_reg <= row_reg + 2'd1;
        end
    end

    // row buffer payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int k = 0; k < 9; k++)
                ent_buf_reg[k] <= ent_reg[k];
            for (int k = 0; k < 3; k++)
                trans_buf_reg[k] <= trans_reg[k];
            view_buf_reg <= carry_reg[ST_R].view_angle;
        end
    end

    // output row select
    assign row_valid = bvld_reg;
    always_comb
    begin
        row_data           = '0;
        row_data.row_index = row_reg;
        row_data.view_out  = view_buf_reg;
        row_data.last_row  = (row_reg == cpose_pkg::ROW_BOT);
        case (row_reg)
            cpose_pkg::ROW_TOP:
            begin
                row_data.entry_a    = ent_buf_reg[0];
                row_data.entry_b    = ent_buf_reg[1];
                row_data.entry_c    = ent_buf_reg[2];
                row_data.shift_part = trans_buf_reg[0];
            end
            cpose_pkg::ROW_MID:
            begin
                row_data.entry_a    = ent_buf_reg[3];
                row_data.entry_b    = ent_buf_reg[4];
                row_data.entry_c    = ent_buf_reg[5];
                row_data.shift_part = trans_buf_reg[1];
            end
            cpose_pkg::ROW_BOT:
            begin
                row_data.entry_a    = ent_buf_reg[6];
                row_data.entry_b    = ent_buf_reg[7];
                row_data.entry_c    = ent_buf_reg[8];
                row_data.shift_part = trans_buf_reg[2];
            end
            default:
            begin
                row_data.entry_a    = '0;
                row_data.entry_b    = '0;
                row_data.entry_c    = '0;
                row_data.shift_part = '0;
            end
        endcase
    end

    // an accepted input lands in the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        angle_valid && !angle_stall |=> vld_reg[0])
        else $error("accepted input missing from first stage");

    // a full tail stage that cannot drain is kept
    a_tail_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_R] && !advance |=> vld_reg[ST_R])
        else $error("tail stage lost while stalled");

    // rows of one pose come out in order
    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        bvld_reg && !row_stall && row_reg != cpose_pkg::ROW_BOT
        |=> bvld_reg && row_reg == $past(row_reg) + 2'd1)
        else $error("pose row sequence broken");

    // row counter never leaves the three rows
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        bvld_reg |-> row_reg == cpose_pkg::ROW_TOP || row_reg == cpose_pkg::ROW_MID
                     || row_reg == cpose_pkg::ROW_BOT)
        else $error("row counter out of range");

    // rotation entries stay saturated to plus or minus one
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid |-> row_data.entry_a <= cpose_pkg::Q14_ONE
                   && row_data.entry_a >= -cpose_pkg::Q14_ONE
                   && row_data.entry_b <= cpose_pkg::Q14_ONE
                   && row_data.entry_b >= -cpose_pkg::Q14_ONE
                   && row_data.entry_c <= cpose_pkg::Q14_ONE
                   && row_data.entry_c >= -cpose_pkg::Q14_ONE)
        else $error("rotation entry beyond saturation limit");

endmodule
